### rtl/tpt_pkg.sv
package tpt_pkg;

  localparam int COORD_W     = 16;
  localparam int THICK_W     = 15;
  localparam int MAG_W       = 16;
  localparam int BIT_W       = 4;
  localparam logic [THICK_W-1:0] THICK_RESET = 15'd41;
  localparam logic [BIT_W-1:0]   BIT_TOP     = 4'd14;
  localparam logic [2:0]         VTX_LAST    = 3'd5;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_FIRST_PT,
    OP_PAIR_OFF,
    OP_SHIFT,
    OP_DIFF,
    OP_SQX,
    OP_SQY,
    OP_SUM,
    OP_RPRE,
    OP_RCAP,
    OP_IA,
    OP_IB,
    OP_IC,
    OP_OFF,
    OP_EMIT
  } dp_op_t;

  // Segment that an emitted vertex belongs to
  typedef enum logic {
    SEG_FIRST,
    SEG_LAST
  } seg_t;

  typedef struct packed {
    dp_op_t           op;
    logic             comp;
    logic [BIT_W-1:0] bit_idx;
    seg_t             seg;
    logic [2:0]       vtx;
    logic             run_end;
    logic             line_end;
  } tpt_cmd_t;

  typedef struct packed {
    logic zero_diff;
    logic out_free;
  } tpt_stat_t;

  // Clamp a 17-bit signed sum to the 16-bit signed range
  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [COORD_W:0] v);
    logic [COORD_W-1:0] res;
    if (v[COORD_W] != v[COORD_W-1]) begin
      res = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

### rtl/tpt_dp.sv
module tpt_dp import tpt_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic signed [COORD_W-1:0] px,
  input  logic signed [COORD_W-1:0] py,
  input  logic                      thickness_we,
  input  logic [THICK_W-1:0]        thickness,
  input  tpt_cmd_t                  cmd,
  output tpt_stat_t                 stat,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [COORD_W-1:0]        vx,
  output logic [COORD_W-1:0]        vy,
  output logic                      run_end,
  output logic                      line_end
);

  logic [THICK_W-1:0]        thick;
  logic signed [COORD_W-1:0] cur_x, cur_y, prev_x, prev_y, older_x, older_y;
  logic signed [COORD_W-1:0] older_off_x, older_off_y, new_off_x, new_off_y;
  logic [MAG_W-1:0]          mx, my;
  logic                      dx_neg, dy_pos, zero_diff;
  logic [2*THICK_W-1:0]      tt;
  logic [31:0]               msx, msy, aq;
  logic [32:0]               s;
  logic [63:0]               prod, rr;
  logic [THICK_W-1:0]        r, rx;

  logic signed [COORD_W:0]   dxw, dyw;
  logic [THICK_W-1:0]        cand;
  logic [MAG_W-1:0]          c2;
  logic [31:0]               op_a, op_b;
  logic [63:0]               mul_res;
  logic [64:0]               tot;
  logic signed [COORD_W-1:0] base_x, base_y, off_x, off_y;
  logic signed [COORD_W:0]   sum_x, sum_y;
  logic                      use_b, neg;

  // Neighbor difference
  assign dxw = {cur_x[COORD_W-1], cur_x} - {older_x[COORD_W-1], older_x};
  assign dyw = {cur_y[COORD_W-1], cur_y} - {older_y[COORD_W-1], older_y};

  // Candidate bit of the rounding search
  assign cand = r | (THICK_W'(1) << cmd.bit_idx);
  assign c2   = {cand, 1'b0} - MAG_W'(1);

  // Shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.op)
      OP_SQX:  begin op_a = 32'(mx); op_b = 32'(mx); end
      OP_SQY:  begin op_a = 32'(my); op_b = 32'(my); end
      OP_RPRE: begin op_a = 32'(tt); op_b = cmd.comp ? msx : msy; end
      OP_IA:   begin op_a = 32'(c2); op_b = 32'(c2); end
      OP_IB:   begin op_a = prod[31:0]; op_b = s[31:0]; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign mul_res = op_a * op_b;
  assign tot     = {1'b0, prod} + (s[32] ? {1'b0, aq, 32'b0} : 65'd0);

  // Vertex select: A+oA, A-oA, B-oB, B-oB, B+oB, A+oA
  always_comb begin
    use_b = (cmd.vtx == 3'd2) || (cmd.vtx == 3'd3) || (cmd.vtx == 3'd4);
    neg   = (cmd.vtx == 3'd1) || (cmd.vtx == 3'd2) || (cmd.vtx == 3'd3);
    if (cmd.seg == SEG_FIRST) begin
      base_x = use_b ? prev_x : older_x;
      base_y = use_b ? prev_y : older_y;
      off_x  = use_b ? new_off_x : older_off_x;
      off_y  = use_b ? new_off_y : older_off_y;
    end else begin
      base_x = use_b ? cur_x : prev_x;
      base_y = use_b ? cur_y : prev_y;
      off_x  = use_b ? '0 : new_off_x;
      off_y  = use_b ? $signed({1'b0, thick}) : new_off_y;
    end
    sum_x = neg ? {base_x[COORD_W-1], base_x} - {off_x[COORD_W-1], off_x}
                : {base_x[COORD_W-1], base_x} + {off_x[COORD_W-1], off_x};
    sum_y = neg ? {base_y[COORD_W-1], base_y} - {off_y[COORD_W-1], off_y}
                : {base_y[COORD_W-1], base_y} + {off_y[COORD_W-1], off_y};
  end

  // Thickness register
  always_ff @(posedge clk) begin
    if (rst) begin
      thick <= THICK_RESET;
    end else if (thickness_we) begin
      thick <= thickness;
    end
  end

  // Point and offset datapath
  always_ff @(posedge clk) begin
    if (load) begin
      cur_x <= px;
      cur_y <= py;
    end
    case (cmd.op)
      OP_FIRST_PT: begin
        prev_x <= cur_x;
        prev_y <= cur_y;
      end
      OP_PAIR_OFF: begin
        new_off_x <= '0;
        new_off_y <= $signed({1'b0, thick});
      end
      OP_SHIFT: begin
        older_x     <= prev_x;
        older_y     <= prev_y;
        older_off_x <= new_off_x;
        older_off_y <= new_off_y;
        prev_x      <= cur_x;
        prev_y      <= cur_y;
      end
      OP_DIFF: begin
        mx        <= dxw[COORD_W] ? MAG_W'(-dxw) : dxw[MAG_W-1:0];
        my        <= dyw[COORD_W] ? MAG_W'(-dyw) : dyw[MAG_W-1:0];
        dx_neg    <= dxw[COORD_W];
        dy_pos    <= !dyw[COORD_W] && (dyw != '0);
        zero_diff <= (dxw == '0) && (dyw == '0);
        tt        <= thick * thick;
      end
      OP_SQX: prod <= mul_res;
      OP_SQY: begin
        msx  <= prod[31:0];
        prod <= mul_res;
      end
      OP_SUM: begin
        msy <= prod[31:0];
        s   <= {1'b0, msx} + {1'b0, prod[31:0]};
      end
      OP_RPRE: begin
        prod <= mul_res;
        if (cmd.comp) begin
          rx <= r;
        end
      end
      OP_RCAP: begin
        rr <= {prod[61:0], 2'b00};
        r  <= '0;
      end
      OP_IA: prod <= mul_res;
      OP_IB: begin
        aq   <= prod[31:0];
        prod <= mul_res;
      end
      OP_IC: begin
        if ((tot <= {1'b0, rr}) && (cand <= thick)) begin
          r <= cand;
        end
      end
      OP_OFF: begin
        new_off_x <= dy_pos ? -$signed({1'b0, rx}) : $signed({1'b0, rx});
        new_off_y <= dx_neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      vx       <= sat_coord(sum_x);
      vy       <= sat_coord(sum_y);
      run_end  <= cmd.run_end;
      line_end <= cmd.line_end;
    end
  end

  assign stat.zero_diff = zero_diff;
  assign stat.out_free  = !out_valid || !out_stall;

endmodule

### rtl/tpt_ctrl.sv
module tpt_ctrl import tpt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      final_point,
  output logic      in_stall,
  output logic      load,
  output tpt_cmd_t  cmd,
  input  tpt_stat_t stat
);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_DISP  = 13'b0000000000010,
    ST_SQX   = 13'b0000000000100,
    ST_SQY   = 13'b0000000001000,
    ST_SUM   = 13'b0000000010000,
    ST_RPRE  = 13'b0000000100000,
    ST_RCAP  = 13'b0000001000000,
    ST_IA    = 13'b0000010000000,
    ST_IB    = 13'b0000100000000,
    ST_IC    = 13'b0001000000000,
    ST_OFF   = 13'b0010000000000,
    ST_EMIT  = 13'b0100000000000,
    ST_SHIFT = 13'b1000000000000
  } state_t;

  state_t           state, state_next;
  logic [1:0]       ps, ps_next;
  logic             fin;
  logic             comp, comp_next;
  logic [BIT_W-1:0] bit_idx, bit_idx_next;
  seg_t             seg, seg_next;
  logic [2:0]       vtx, vtx_next;
  logic             last_seg;

  assign in_stall = (state != ST_IDLE);
  assign load     = in_valid && !in_stall;
  assign last_seg = (seg == SEG_LAST) || !fin;

  // Next state and command decode
  always_comb begin
    state_next   = state;
    ps_next      = ps;
    comp_next    = comp;
    bit_idx_next = bit_idx;
    seg_next     = seg;
    vtx_next     = vtx;
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.comp     = comp;
    cmd.bit_idx  = bit_idx;
    cmd.seg      = seg;
    cmd.vtx      = vtx;
    unique case (state)
      ST_IDLE: begin
        if (load) begin
          state_next = ST_DISP;
        end
      end
      ST_DISP: begin
        seg_next = SEG_FIRST;
        vtx_next = '0;
        if (ps == 2'd0) begin
          cmd.op     = OP_FIRST_PT;
          ps_next    = fin ? 2'd0 : 2'd1;
          state_next = ST_IDLE;
        end else if (ps == 2'd1) begin
          cmd.op = OP_PAIR_OFF;
          if (fin) begin
            seg_next   = SEG_LAST;
            state_next = ST_EMIT;
          end else begin
            state_next = ST_SHIFT;
          end
        end else begin
          cmd.op     = OP_DIFF;
          state_next = ST_SQX;
        end
      end
      ST_SQX: begin
        if (stat.zero_diff) begin
          cmd.op     = OP_PAIR_OFF;
          state_next = ST_EMIT;
        end else begin
          cmd.op     = OP_SQX;
          state_next = ST_SQY;
        end
      end
      ST_SQY: begin
        cmd.op     = OP_SQY;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.op     = OP_SUM;
        comp_next  = 1'b0;
        state_next = ST_RPRE;
      end
      ST_RPRE: begin
        cmd.op     = OP_RPRE;
        state_next = ST_RCAP;
      end
      ST_RCAP: begin
        cmd.op       = OP_RCAP;
        bit_idx_next = BIT_TOP;
        state_next   = ST_IA;
      end
      ST_IA: begin
        cmd.op     = OP_IA;
        state_next = ST_IB;
      end
      ST_IB: begin
        cmd.op     = OP_IB;
        state_next = ST_IC;
      end
      ST_IC: begin
        cmd.op = OP_IC;
        if (bit_idx != '0) begin
          bit_idx_next = bit_idx - BIT_W'(1);
          state_next   = ST_IA;
        end else if (!comp) begin
          comp_next  = 1'b1;
          state_next = ST_RPRE;
        end else begin
          state_next = ST_OFF;
        end
      end
      ST_OFF: begin
        cmd.op     = OP_OFF;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.op       = OP_EMIT;
          cmd.run_end  = (vtx == VTX_LAST) && last_seg;
          cmd.line_end = (vtx == VTX_LAST) && last_seg && fin;
          if (vtx != VTX_LAST) begin
            vtx_next = vtx + 3'd1;
          end else if (!last_seg) begin
            seg_next = SEG_LAST;
            vtx_next = '0;
          end else if (fin) begin
            ps_next    = 2'd0;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        cmd.op     = OP_SHIFT;
        ps_next    = 2'd2;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ps    <= 2'd0;
    end else begin
      state <= state_next;
      ps    <= ps_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fin <= final_point;
    end
    comp    <= comp_next;
    bit_idx <= bit_idx_next;
    seg     <= seg_next;
    vtx     <= vtx_next;
  end

  // Point count saturates at two
  a_ps_range: assert property (@(posedge clk) disable iff (rst) ps != 2'd3)
    else $error("point count out of range");

  // A transfer in always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    load |=> (state == ST_DISP))
    else $error("accepted point not dispatched");

  // Vertices only go out when the output register can take them
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT) |-> stat.out_free)
    else $error("vertex emitted into a full output register");

  // Search bit counter stays within the thickness width
  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IC) |-> (bit_idx <= BIT_TOP))
    else $error("search bit out of range");

endmodule

### rtl/thick_polyline_tessellator_top.sv
// Channel   Handshake             Payload
// ------    --------------------  ------------------------------
// input     in_valid / in_stall   px, py, final_point
// output    out_valid / out_stall vx, vy, run_end, line_end
// config    thickness_we          thickness
//
// A point that emits nothing passes through dispatch, and through a shift when
// it is the second point of a line. A closing second point emits 6 vertices; a
// zero-difference interior point emits 6 or 12. Any other interior point runs
// the offset search (two components, 15 search bits each on the shared 32x32
// multiplier), then emits 6 or 12 vertices and, if not final, shifts its points.
// Reset (rst, synchronous) clears the point count and sets thickness to 41.
// Output stalls hold the vertex sequence; the input stalls while a point is worked.
module thick_polyline_tessellator_top import tpt_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] px,
  input  logic signed [COORD_W-1:0] py,
  input  logic                      final_point,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] vx,
  output logic signed [COORD_W-1:0] vy,
  output logic                      run_end,
  output logic                      line_end,
  input  logic                      thickness_we,
  input  logic [THICK_W-1:0]        thickness
);

  tpt_cmd_t  cmd;
  tpt_stat_t stat;
  logic      load;

  tpt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .final_point (final_point),
    .in_stall    (in_stall),
    .load        (load),
    .cmd         (cmd),
    .stat        (stat)
  );

  tpt_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .px           (px),
    .py           (py),
    .thickness_we (thickness_we),
    .thickness    (thickness),
    .cmd          (cmd),
    .stat         (stat),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .vx           (vx),
    .vy           (vy),
    .run_end      (run_end),
    .line_end     (line_end)
  );

endmodule
